// ----- hw/rtl/wcls_pkg.sv -----
// ---------------------------------------------------------------------------
// wcls_pkg
// Shared types and operation codes for the 256-bit compare, logic and shift
// ALU pipeline.
// ---------------------------------------------------------------------------
package wcls_pkg;

    // Operation codes; codes 14 and 15 are unused and report invalid opcode.
    typedef enum logic [3:0] {
        F_LT     = 4'd0,
        F_GT     = 4'd1,
        F_SLT    = 4'd2,
        F_SGT    = 4'd3,
        F_EQ     = 4'd4,
        F_ISZERO = 4'd5,
        F_AND    = 4'd6,
        F_OR     = 4'd7,
        F_XOR    = 4'd8,
        F_NOT    = 4'd9,
        F_BYTE   = 4'd10,
        F_SHL    = 4'd11,
        F_SHR    = 4'd12,
        F_SAR    = 4'd13
    } t_func;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned DATA_W = 256;

    // Partial results carried from the front stage to the back stage.
    typedef struct packed {
        t_func               func;
        logic                bad;        // invalid opcode or disabled shift
        logic [DATA_W-1:0]   logic_res;  // AND, OR, XOR or NOT result
        logic [DATA_W-1:0]   shifted;    // operand after whole-word shift
        logic                fill;       // fill bit for right shifts
        logic [5:0]          shamt;      // bit shift within a word
        logic                in256;      // shift count below 256
        logic                in32;       // byte index below 32
        logic [3:0]          lt_w;       // per-word unsigned less-than
        logic [3:0]          eq_w;       // per-word equality
        logic                lt_s3;      // signed less-than on the top word
        logic                iszero;     // first operand is zero
        logic [WORD_W-1:0]   byte_word;  // word that holds the selected byte
        logic [2:0]          byte_sel;   // byte index within that word
    } t_s1;

    // Final result of one transaction.
    typedef struct packed {
        logic [DATA_W-1:0]   result;
        logic                status;
    } t_s2;

endpackage

// ----- hw/rtl/wcls_front.sv -----
// ---------------------------------------------------------------------------
// wcls_front
// First stage: per-word compares, bitwise operations, range checks, whole-word
// shift and byte word selection.
// ---------------------------------------------------------------------------
module wcls_front (
    input  wcls_pkg::t_func     i_func,
    input  logic [255:0]        i_a,
    input  logic [255:0]        i_b,
    input  logic                i_shift_en,
    output wcls_pkg::t_s1       o_s1
);

    logic                is_shift;
    logic                fill;
    logic [255:0]        left_c;
    logic [255:0]        right_c;
    logic [1:0]          byte_wsel;
    logic [255:0]        logic_res;
    logic                bad;

    assign is_shift = (i_func == wcls_pkg::F_SHL) || (i_func == wcls_pkg::F_SHR) ||
                      (i_func == wcls_pkg::F_SAR);
    assign fill     = (i_func == wcls_pkg::F_SAR) & i_b[255];

    // Whole-word shifts by the count's bits 7..6.
    always_comb begin
        case (i_a[7:6])
            2'd0: begin
                left_c  = i_b;
                right_c = i_b;
            end
            2'd1: begin
                left_c  = {i_b[191:0], 64'd0};
                right_c = {{64{fill}}, i_b[255:64]};
            end
            2'd2: begin
                left_c  = {i_b[127:0], 128'd0};
                right_c = {{128{fill}}, i_b[255:128]};
            end
            default: begin
                left_c  = {i_b[63:0], 192'd0};
                right_c = {{192{fill}}, i_b[255:192]};
            end
        endcase
    end

    // Index 0 is the most significant byte, so the word index is inverted.
    assign byte_wsel = ~i_a[4:3];

    always_comb begin
        o_s1.func      = i_func;
        o_s1.bad       = bad;
        o_s1.logic_res = logic_res;
        o_s1.fill      = fill;
        o_s1.shamt     = i_a[5:0];
        o_s1.shifted   = (i_func == wcls_pkg::F_SHL) ? left_c : right_c;
        o_s1.in256     = (i_a[255:8] == 248'd0);
        o_s1.in32      = (i_a[255:5] == 251'd0);
        o_s1.iszero    = (i_a == 256'd0);
        o_s1.byte_word = i_b[byte_wsel*64 +: 64];
        o_s1.byte_sel  = ~i_a[2:0];
        o_s1.lt_s3     = $signed(i_a[255:192]) < $signed(i_b[255:192]);
        for (int i = 0; i < 4; i++) begin
            o_s1.lt_w[i] = i_a[i*64 +: 64] < i_b[i*64 +: 64];
            o_s1.eq_w[i] = i_a[i*64 +: 64] == i_b[i*64 +: 64];
        end
    end

    // Bitwise operations and the invalid opcode decision.
    always_comb begin
        logic_res = 256'd0;
        bad       = 1'b0;
        case (i_func)
            wcls_pkg::F_AND: logic_res = i_a & i_b;
            wcls_pkg::F_OR:  logic_res = i_a | i_b;
            wcls_pkg::F_XOR: logic_res = i_a ^ i_b;
            wcls_pkg::F_NOT: logic_res = ~i_a;
            wcls_pkg::F_LT, wcls_pkg::F_GT, wcls_pkg::F_SLT, wcls_pkg::F_SGT,
            wcls_pkg::F_EQ, wcls_pkg::F_ISZERO, wcls_pkg::F_BYTE: begin
                bad = 1'b0;
            end
            wcls_pkg::F_SHL, wcls_pkg::F_SHR, wcls_pkg::F_SAR: begin
                bad = is_shift & ~i_shift_en;
            end
            default: bad = 1'b1;
        endcase
    end

endmodule

// ----- hw/rtl/wcls_back.sv -----
// ---------------------------------------------------------------------------
// wcls_back
// Second stage: bit shift within a word, compare combine, byte extract and
// final result selection.
// ---------------------------------------------------------------------------
module wcls_back (
    input  wcls_pkg::t_s1   i_s1,
    output wcls_pkg::t_s2   o_s2
);

    logic [255:0]  left_f;
    logic [319:0]  right_wide;
    logic [255:0]  right_f;
    logic          lt_low;
    logic          lt_u;
    logic          lt_s;
    logic          eq_all;
    logic [7:0]    sel_byte;

    // Bit shifts of 0..63 after the whole-word shift.
    assign left_f     = i_s1.shifted << i_s1.shamt;
    assign right_wide = {{64{i_s1.fill}}, i_s1.shifted} >> i_s1.shamt;
    assign right_f    = right_wide[255:0];

    // Combine per-word flags from the most significant word down.
    assign lt_low = i_s1.lt_w[2] | (i_s1.eq_w[2] &
                    (i_s1.lt_w[1] | (i_s1.eq_w[1] & i_s1.lt_w[0])));
    assign eq_all = &i_s1.eq_w;
    assign lt_u   = i_s1.lt_w[3] | (i_s1.eq_w[3] & lt_low);
    assign lt_s   = i_s1.lt_s3   | (i_s1.eq_w[3] & lt_low);

    assign sel_byte = i_s1.byte_word[{i_s1.byte_sel, 3'b000} +: 8];

    // Result selection.
    always_comb begin
        o_s2.status = i_s1.bad;
        o_s2.result = 256'd0;
        if (!i_s1.bad) begin
            case (i_s1.func)
                wcls_pkg::F_LT:     o_s2.result = {255'd0, lt_u};
                wcls_pkg::F_GT:     o_s2.result = {255'd0, ~lt_u & ~eq_all};
                wcls_pkg::F_SLT:    o_s2.result = {255'd0, lt_s};
                wcls_pkg::F_SGT:    o_s2.result = {255'd0, ~lt_s & ~eq_all};
                wcls_pkg::F_EQ:     o_s2.result = {255'd0, eq_all};
                wcls_pkg::F_ISZERO: o_s2.result = {255'd0, i_s1.iszero};
                wcls_pkg::F_AND, wcls_pkg::F_OR, wcls_pkg::F_XOR, wcls_pkg::F_NOT: begin
                    o_s2.result = i_s1.logic_res;
                end
                wcls_pkg::F_BYTE: o_s2.result = i_s1.in32 ? {248'd0, sel_byte} : 256'd0;
                wcls_pkg::F_SHL:  o_s2.result = i_s1.in256 ? left_f : 256'd0;
                wcls_pkg::F_SHR:  o_s2.result = i_s1.in256 ? right_f : 256'd0;
                wcls_pkg::F_SAR:  o_s2.result = i_s1.in256 ? right_f : {256{i_s1.fill}};
                default:          o_s2.result = 256'd0;
            endcase
        end
    end

endmodule

// ----- hw/rtl/word256_compare_logic_shift_alu.sv -----
// ---------------------------------------------------------------------------
// word256_compare_logic_shift_alu
// Pipelined 256-bit compare, bitwise, byte select and shift ALU.
//
//   Channel   Handshake           Payload
//   input     i_valid / o_stall   i_func, i_first_w0..3, i_second_w0..3
//   output    o_valid / i_stall   o_result_w0..3, o_status
//   config    i_cfg_we            i_cfg_wdata (shift operations enabled)
//
// A transaction is registered after the front stage in r_s1 when accepted,
// after the back stage in r_s2 and then in the output register r_s3, which
// drives o_valid and the result.
// One transaction is accepted every cycle while the output is not stalled.
// A stall holds only the stages that are full; empty stages keep filling.
// Reset clears all stage valid bits and enables shift operations.
// ---------------------------------------------------------------------------
module word256_compare_logic_shift_alu (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [3:0]    i_func,
    input  logic [63:0]   i_first_w0,
    input  logic [63:0]   i_first_w1,
    input  logic [63:0]   i_first_w2,
    input  logic [63:0]   i_first_w3,
    input  logic [63:0]   i_second_w0,
    input  logic [63:0]   i_second_w1,
    input  logic [63:0]   i_second_w2,
    input  logic [63:0]   i_second_w3,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [63:0]   o_result_w0,
    output logic [63:0]   o_result_w1,
    output logic [63:0]   o_result_w2,
    output logic [63:0]   o_result_w3,
    output logic          o_status
);

    logic             r_shift_en;
    logic             r_v1;
    logic             r_v2;
    logic             r_v3;
    wcls_pkg::t_s1    n_s1;
    wcls_pkg::t_s1    r_s1;
    wcls_pkg::t_s2    n_s2;
    wcls_pkg::t_s2    r_s2;
    wcls_pkg::t_s2    r_s3;
    logic             adv1;
    logic             adv2;
    logic             adv3;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_shift_en <= i_cfg_wdata;
        end
    end

    // A stage may load when it is empty or the stage after it moves.
    assign adv3    = ~r_v3 | ~i_stall;
    assign adv2    = ~r_v2 | adv3;
    assign adv1    = ~r_v1 | adv2;
    assign o_stall = ~adv1;

    // Front stage.
    wcls_front u_front (
        .i_func     (wcls_pkg::t_func'(i_func)),
        .i_a        ({i_first_w3, i_first_w2, i_first_w1, i_first_w0}),
        .i_b        ({i_second_w3, i_second_w2, i_second_w1, i_second_w0}),
        .i_shift_en (r_shift_en),
        .o_s1       (n_s1)
    );

    // Back stage.
    wcls_back u_back (
        .i_s1 (r_s1),
        .o_s2 (n_s2)
    );

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1 <= n_s1;
        end
        if (adv2) begin
            r_s2 <= n_s2;
        end
        if (adv3) begin
            r_s3 <= r_s2;
        end
    end

    assign o_valid     = r_v3;
    assign o_result_w0 = r_s3.result[63:0];
    assign o_result_w1 = r_s3.result[127:64];
    assign o_result_w2 = r_s3.result[191:128];
    assign o_result_w3 = r_s3.result[255:192];
    assign o_status    = r_s3.status;

endmodule

// ----- hw/rtl/wcls_checker.sv -----
// ---------------------------------------------------------------------------
// wcls_checker
// Port-level checks for the ALU pipeline, bound to the top level.
// ---------------------------------------------------------------------------
module wcls_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          o_stall,
    input  logic          o_valid,
    input  logic          i_stall,
    input  logic [63:0]   o_result_w0,
    input  logic [63:0]   o_result_w1,
    input  logic [63:0]   o_result_w2,
    input  logic [63:0]   o_result_w3,
    input  logic          o_status
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // An empty output stage lets the whole pipeline move.
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output stage is empty");

    // An invalid opcode always returns a zero result.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_result_w0 == 64'd0 && o_result_w1 == 64'd0 &&
                                   o_result_w2 == 64'd0 && o_result_w3 == 64'd0))
        else $error("invalid opcode with nonzero result");

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped under stall");

endmodule

bind word256_compare_logic_shift_alu wcls_checker u_wcls_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the 256-bit compare, logic and shift ALU. A
// scoreboard works out each result from the operands that the block accepts
// and matches it, word by word, against the results that come out. Directed
// corner cases run first, then random traffic under three idling patterns,
// with the shift enable changed within each phase.
// ---------------------------------------------------------------------------
module testbench;

    // Operation codes that the block does not implement.
    localparam logic [3:0] FUNC_SPARE_LO = 4'd14;
    localparam logic [3:0] FUNC_SPARE_HI = 4'd15;

    localparam logic [255:0] ALL_ONES = '1;
    localparam logic [255:0] MOST_NEG = {1'b1, 255'b0};
    localparam logic [255:0] MOST_POS = {1'b0, {255{1'b1}}};
    // Every byte distinct, so that byte selection errors show.
    localparam logic [255:0] BYTE_RAMP =
        256'h3f3e3d3c3b3a39383736353433323130_2f2e2d2c2b2a29282726252423222120;
    localparam int RANDOM_PER_STEP = 230;
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic [3:0]   func;
        logic [255:0] first;
        logic [255:0] second;
    } alu_op_t;

    typedef struct packed {
        logic [255:0] value;
        logic         status;
    } alu_res_t;

    // Predicts each result and matches it against what the block returns.
    class alu_scoreboard;
        bit       shift_en;
        int       error_count;
        alu_res_t results_due[$];

        function new();
            shift_en = 1'b1;
            error_count = 0;
        endfunction

        function alu_res_t alu_compute(alu_op_t op);
            logic [255:0] a;
            logic [255:0] b;
            alu_res_t     res;
            int           pos;
            a = op.first;
            b = op.second;
            res.value = '0;
            res.status = 1'b0;
            if ((op.func == wcls_pkg::F_SHL || op.func == wcls_pkg::F_SHR ||
                 op.func == wcls_pkg::F_SAR) && !shift_en) begin
                res.status = 1'b1;
            end else begin
                case (op.func)
                    wcls_pkg::F_LT:     res.value = 256'(a < b);
                    wcls_pkg::F_GT:     res.value = 256'(a > b);
                    wcls_pkg::F_SLT:    res.value = 256'($signed(a) < $signed(b));
                    wcls_pkg::F_SGT:    res.value = 256'($signed(a) > $signed(b));
                    wcls_pkg::F_EQ:     res.value = 256'(a == b);
                    wcls_pkg::F_ISZERO: res.value = 256'(a == '0);
                    wcls_pkg::F_AND:    res.value = a & b;
                    wcls_pkg::F_OR:     res.value = a | b;
                    wcls_pkg::F_XOR:    res.value = a ^ b;
                    wcls_pkg::F_NOT:    res.value = ~a;
                    wcls_pkg::F_BYTE: begin
                        // Byte zero is the most significant one.
                        if (a < 32) begin
                            pos = 8 * (31 - int'(a[4:0]));
                            res.value = (b >> pos) & 256'hff;
                        end
                    end
                    wcls_pkg::F_SHL: begin
                        if (a < 256) res.value = b << a[7:0];
                    end
                    wcls_pkg::F_SHR: begin
                        if (a < 256) res.value = b >> a[7:0];
                    end
                    wcls_pkg::F_SAR: begin
                        if (a < 256) res.value = $signed(b) >>> a[7:0];
                        else res.value = {256{b[255]}};
                    end
                    default: res.status = 1'b1;
                endcase
            end
            return res;
        endfunction

        function void note_input(alu_op_t op);
            results_due.push_back(alu_compute(op));
        endfunction

        function void check_result(alu_res_t got);
            alu_res_t want;
            int       k;
            if (results_due.size() == 0) begin
                $display("%0t: result with no transaction outstanding: %h status %0b",
                         $time, got.value, got.status);
                error_count++;
                return;
            end
            want = results_due.pop_front();
            for (k = 0; k < 4; k++) begin
                if (got.value[k*64 +: 64] !== want.value[k*64 +: 64]) begin
                    $display("%0t: result_w%0d expected %h actual %h", $time, k,
                             want.value[k*64 +: 64], got.value[k*64 +: 64]);
                    error_count++;
                end
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0b actual %0b", $time,
                         want.status, got.status);
                error_count++;
            end
        endfunction

        function int pending();
            return results_due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [3:0]  i_func = '0;
    logic [63:0] i_first_w0 = '0;
    logic [63:0] i_first_w1 = '0;
    logic [63:0] i_first_w2 = '0;
    logic [63:0] i_first_w3 = '0;
    logic [63:0] i_second_w0 = '0;
    logic [63:0] i_second_w1 = '0;
    logic [63:0] i_second_w2 = '0;
    logic [63:0] i_second_w3 = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_result_w0;
    logic [63:0] o_result_w1;
    logic [63:0] o_result_w2;
    logic [63:0] o_result_w3;
    logic        o_status;

    int            send_gap_pct = 0;
    int            stall_pct = 0;
    alu_scoreboard sb;

    word256_compare_logic_shift_alu dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_first_w0  (i_first_w0),
        .i_first_w1  (i_first_w1),
        .i_first_w2  (i_first_w2),
        .i_first_w3  (i_first_w3),
        .i_second_w0 (i_second_w0),
        .i_second_w1 (i_second_w1),
        .i_second_w2 (i_second_w2),
        .i_second_w3 (i_second_w3),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result_w0 (o_result_w0),
        .o_result_w1 (o_result_w1),
        .o_result_w2 (o_result_w2),
        .o_result_w3 (o_result_w3),
        .o_status    (o_status)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Random back-pressure on the result channel.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Every accepted result goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result({o_result_w3, o_result_w2, o_result_w1, o_result_w0, o_status});
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7fff_ffff_ffff_ffff;
            4: return 64'($urandom_range(0, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [255:0] rand_value();
        return {rand_word(), rand_word(), rand_word(), rand_word()};
    endfunction

    // Byte indexes and shift counts: mostly near the in-range limits.
    function automatic logic [255:0] rand_count();
        logic [255:0] v;
        case ($urandom_range(0, 5))
            0: v = 256'($urandom_range(0, 40));
            1, 2: v = 256'($urandom_range(0, 300));
            3: begin
                v = rand_value();
                v[63:0] = 64'($urandom_range(0, 255));
            end
            default: v = rand_value();
        endcase
        return v;
    endfunction

    function automatic alu_op_t make_op(logic [3:0] func, logic [255:0] first,
                                        logic [255:0] second);
        alu_op_t op;
        op.func = func;
        op.first = first;
        op.second = second;
        return op;
    endfunction

    function automatic alu_op_t rand_op();
        alu_op_t op;
        int      k;
        op.func = 4'($urandom_range(0, FUNC_SPARE_HI));
        if (op.func == wcls_pkg::F_BYTE || op.func == wcls_pkg::F_SHL ||
            op.func == wcls_pkg::F_SHR || op.func == wcls_pkg::F_SAR)
            op.first = rand_count();
        else
            op.first = rand_value();
        op.second = rand_value();
        // Comparisons need equal and nearly equal operands to be of interest.
        if (op.func <= wcls_pkg::F_EQ && $urandom_range(0, 99) < 40) begin
            op.second = op.first;
            if ($urandom_range(0, 1)) begin
                k = $urandom_range(0, 3);
                op.second[k*64 +: 64] = rand_word();
            end
        end
        return op;
    endfunction

    // Offers one transaction, with random gaps ahead of it, until accepted.
    task automatic send_op(input alu_op_t op);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_func      <= op.func;
        i_first_w0  <= op.first[63:0];
        i_first_w1  <= op.first[127:64];
        i_first_w2  <= op.first[191:128];
        i_first_w3  <= op.first[255:192];
        i_second_w0 <= op.second[63:0];
        i_second_w1 <= op.second[127:64];
        i_second_w2 <= op.second[191:128];
        i_second_w3 <= op.second[255:192];
        do @(posedge i_clk); while (o_stall);
        sb.note_input(op);
    endtask

    task automatic wait_drain();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // The enable is changed only with nothing in flight.
    task automatic write_shift_enable(input logic enable);
        i_valid <= 1'b0;
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= enable;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.shift_en = enable;
    endtask

    // Run limit, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int phase;
        int half;
        int n;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corner cases with shifts enabled as after reset.
        send_op(make_op(wcls_pkg::F_LT, '0, 256'd1));
        send_op(make_op(wcls_pkg::F_LT, ALL_ONES, ALL_ONES));
        send_op(make_op(wcls_pkg::F_GT, ALL_ONES, '0));
        send_op(make_op(wcls_pkg::F_SLT, ALL_ONES, '0));
        send_op(make_op(wcls_pkg::F_SGT, MOST_NEG, MOST_POS));
        send_op(make_op(wcls_pkg::F_EQ, ALL_ONES, ALL_ONES));
        send_op(make_op(wcls_pkg::F_ISZERO, '0, ALL_ONES));
        send_op(make_op(wcls_pkg::F_ISZERO, MOST_NEG, '0));
        send_op(make_op(wcls_pkg::F_AND, ALL_ONES, BYTE_RAMP));
        send_op(make_op(wcls_pkg::F_OR, '0, BYTE_RAMP));
        send_op(make_op(wcls_pkg::F_XOR, ALL_ONES, BYTE_RAMP));
        send_op(make_op(wcls_pkg::F_NOT, '0, ALL_ONES));
        send_op(make_op(wcls_pkg::F_BYTE, '0, BYTE_RAMP));
        send_op(make_op(wcls_pkg::F_BYTE, 256'd31, BYTE_RAMP));
        send_op(make_op(wcls_pkg::F_BYTE, 256'd32, BYTE_RAMP));
        send_op(make_op(wcls_pkg::F_BYTE, {128'd0, 64'd1, 64'd0}, BYTE_RAMP));
        send_op(make_op(wcls_pkg::F_SHL, '0, BYTE_RAMP));
        send_op(make_op(wcls_pkg::F_SHL, 256'd255, ALL_ONES));
        send_op(make_op(wcls_pkg::F_SHL, 256'd256, ALL_ONES));
        send_op(make_op(wcls_pkg::F_SHR, {64'd1, 128'd0, 64'd1}, ALL_ONES));
        send_op(make_op(wcls_pkg::F_SAR, 256'd4, MOST_NEG));
        send_op(make_op(wcls_pkg::F_SAR, 256'd256, MOST_NEG));
        send_op(make_op(wcls_pkg::F_SAR, 256'd300, MOST_POS));
        send_op(make_op(FUNC_SPARE_LO, ALL_ONES, ALL_ONES));
        send_op(make_op(FUNC_SPARE_HI, BYTE_RAMP, BYTE_RAMP));

        // Shifts disabled: invalid opcode, while other operations still work.
        write_shift_enable(1'b0);
        send_op(make_op(wcls_pkg::F_SHL, 256'd1, ALL_ONES));
        send_op(make_op(wcls_pkg::F_SHR, 256'd1, ALL_ONES));
        send_op(make_op(wcls_pkg::F_SAR, 256'd300, MOST_NEG));
        send_op(make_op(wcls_pkg::F_AND, ALL_ONES, BYTE_RAMP));

        // Random traffic: slow receiver, then slow sender, then full rate.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct = 31;
                    stall_pct = 70;
                end
                1: begin
                    send_gap_pct = 70;
                    stall_pct = 31;
                end
                default: begin
                    send_gap_pct = 0;
                    stall_pct = 0;
                end
            endcase
            for (half = 0; half < 2; half++) begin
                write_shift_enable(((phase + half) % 2) == 0);
                for (n = 0; n < RANDOM_PER_STEP; n++) send_op(rand_op());
            end
        end

        i_valid <= 1'b0;
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/wcls_pkg.sv
hw/rtl/wcls_front.sv
hw/rtl/wcls_back.sv
hw/rtl/word256_compare_logic_shift_alu.sv
hw/rtl/wcls_checker.sv
tb/testbench.sv
